### rtl/core/cot_pkg.sv
package cot_pkg;

	localparam logic [1:0] CMD_BLOB  = 2'd0;
	localparam logic [1:0] CMD_FRAME = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [2:0] REG_MARGIN   = 3'd0;
	localparam logic [2:0] REG_MOVE     = 3'd1;
	localparam logic [2:0] REG_MIN_AREA = 3'd2;
	localparam logic [2:0] REG_MAX_AREA = 3'd3;
	localparam logic [2:0] REG_RM_START = 3'd4;
	localparam logic [2:0] REG_MIN_LIFE = 3'd5;

	localparam logic [4:0] MAX_RES = 5'd16;
	localparam logic [15:0] LIFE_MAX = 16'hFFFF;

	typedef struct packed {
		logic [15:0] life;
		logic [5:0]  rc;
		logic [15:0] id;
		logic [18:0] area;
		logic [8:0]  y;
		logic [8:0]  x;
	} entry_t;

	typedef struct packed {
		logic [8:0] y;
		logic [8:0] x;
	} blob_t;

	// square window test, inclusive on all four sides
	function automatic logic near(input logic [8:0] ax, input logic [8:0] ay,
		input logic [8:0] bx, input logic [8:0] by, input logic [8:0] m);
		logic signed [10:0] dx;
		logic signed [10:0] dy;
		logic signed [10:0] sm;
		dx = signed'({2'b00, ax}) - signed'({2'b00, bx});
		dy = signed'({2'b00, ay}) - signed'({2'b00, by});
		sm = signed'({2'b00, m});
		return (dx >= -sm) && (dx <= sm) && (dy >= -sm) && (dy <= sm);
	endfunction

endpackage

### rtl/core/cot_ram.sv
module cot_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/centroid_object_tracker.sv
// Centroid object tracker. Send blobs (command 0) with x, y and area, then an
// end-of-frame (command 1); the block answers each end of frame with the
// tracked entries whose life count reached min_life, one transfer each,
// report_total on every transfer and tlast on the final one, or a single
// transfer with tuser (none_reported) set when none qualify. Command 2 clears
// the table and the ID counter. The tracked table and the blob list of the
// frame live in two RAMs with one registered read port each; one item is
// worked on at a time. A blob is matched by reading and comparing each
// table entry in turn. End of frame reads each table entry, reads and
// compares the stored blobs against it, and writes back the updated entry;
// a report pass then reads each entry, waiting for each result to be taken.
// Clear and filtered blobs are done in the idle state. No configuration is read back.
module centroid_object_tracker #(
	parameter int TABLE_DEPTH = 16,
	parameter int FRAME_BLOBS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // command[1:0], blob_x[10:2], blob_y[19:11], blob_area[38:20]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // report_id[15:0], report_x[24:16], report_y[33:25],
	                               // report_area[52:34], report_total[57:53]
	output logic        m_tlast,   // last_report
	output logic        m_tuser,   // none_reported
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [18:0] cfg_data
);

	localparam int TW = $clog2(TABLE_DEPTH);
	localparam int BW = $clog2(FRAME_BLOBS);
	localparam logic [TW:0] TD = (TW+1)'(TABLE_DEPTH);
	localparam logic [BW:0] FB = (BW+1)'(FRAME_BLOBS);
	localparam int EW = $bits(cot_pkg::entry_t);
	localparam int FW = $bits(cot_pkg::blob_t);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_B_RD   = 4'd1;
	localparam logic [3:0] S_B_CHK  = 4'd2;
	localparam logic [3:0] S_F_RD   = 4'd3;
	localparam logic [3:0] S_F_ENT  = 4'd4;
	localparam logic [3:0] S_F_BRD  = 4'd5;
	localparam logic [3:0] S_F_BCHK = 4'd6;
	localparam logic [3:0] S_F_UPD  = 4'd7;
	localparam logic [3:0] S_E_RD   = 4'd8;
	localparam logic [3:0] S_E_GOT  = 4'd9;
	localparam logic [3:0] S_E_OUT  = 4'd10;

	// configuration
	logic [8:0]  margin_q, min_life_q;
	logic        move_q;
	logic [18:0] min_area_q, max_area_q;
	logic [5:0]  rm_start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q   <= 9'd20;
			move_q     <= 1'b1;
			min_area_q <= 19'd655;
			max_area_q <= 19'd16384;
			rm_start_q <= 6'd10;
			min_life_q <= 9'd30;
		end else if (cfg_we) begin
			case (cfg_index)
				cot_pkg::REG_MARGIN:   margin_q   <= cfg_data[8:0];
				cot_pkg::REG_MOVE:     move_q     <= cfg_data[0];
				cot_pkg::REG_MIN_AREA: min_area_q <= cfg_data;
				cot_pkg::REG_MAX_AREA: max_area_q <= cfg_data;
				cot_pkg::REG_RM_START: rm_start_q <= cfg_data[5:0];
				cot_pkg::REG_MIN_LIFE: min_life_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// control state
	logic [3:0]  state_q;
	logic [TW:0] n_q, i_q, w_q;
	logic [BW:0] fbc_q, j_q;
	logic [15:0] next_id_q;
	logic        empty_q, seen_q;
	logic [4:0]  qcnt_q, emit_q;
	cot_pkg::entry_t e_q;
	logic [8:0]  bx_q, by_q;
	logic [18:0] ba_q;

	// output register
	logic        ovalid_q, olast_q, onone_q;
	logic [15:0] oid_q;
	logic [8:0]  ox_q, oy_q;
	logic [18:0] oa_q;
	logic [4:0]  otot_q;

	// input fields
	logic [1:0]  in_cmd;
	logic [8:0]  in_x, in_y;
	logic [18:0] in_a;
	assign in_cmd = s_tdata[1:0];
	assign in_x   = s_tdata[10:2];
	assign in_y   = s_tdata[19:11];
	assign in_a   = s_tdata[38:20];

	logic acc;
	logic blob_ok;
	assign s_tready = (state_q == S_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign blob_ok  = (in_cmd == cot_pkg::CMD_BLOB) && (in_a >= min_area_q)
		&& (in_a <= max_area_q) && (fbc_q < FB);

	// memories
	logic            e_we, f_we;
	logic [TW-1:0]   e_waddr;
	cot_pkg::entry_t e_wdata, e_rdata;
	logic [EW-1:0]   e_rraw;
	cot_pkg::blob_t  f_wdata, f_rdata;
	logic [FW-1:0]   f_rraw;

	assign e_rdata = cot_pkg::entry_t'(e_rraw);
	assign f_rdata = cot_pkg::blob_t'(f_rraw);

	cot_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_entry_ram (
		.clk  (clk),
		.we   (e_we),
		.waddr(e_waddr),
		.wdata(EW'(e_wdata)),
		.raddr(i_q[TW-1:0]),
		.rdata(e_rraw)
	);

	assign f_we    = acc && blob_ok;
	assign f_wdata = '{y: in_y, x: in_x};

	cot_ram #(.WIDTH(FW), .DEPTH(FRAME_BLOBS)) u_blob_ram (
		.clk  (clk),
		.we   (f_we),
		.waddr(fbc_q[BW-1:0]),
		.wdata(FW'(f_wdata)),
		.raddr(j_q[BW-1:0]),
		.rdata(f_rraw)
	);

	// compare results
	logic b_near, f_near;
	assign b_near = cot_pkg::near(bx_q, by_q, e_rdata.x, e_rdata.y, margin_q);
	assign f_near = cot_pkg::near(e_q.x, e_q.y, f_rdata.x, f_rdata.y, margin_q);

	// end of frame update of the held entry
	cot_pkg::entry_t upd;
	logic keep, qual;
	always_comb begin
		upd = e_q;
		if (seen_q) begin
			if (e_q.life != cot_pkg::LIFE_MAX) begin
				upd.life = e_q.life + 16'd1;
			end
		end else if (e_q.rc != 6'd0) begin
			upd.rc = e_q.rc - 6'd1;
		end
	end
	assign keep = (upd.rc != 6'd0);
	assign qual = keep && (upd.life >= {7'd0, min_life_q});

	logic [TW:0] w_next;
	logic [4:0]  qcnt_next;
	assign w_next    = keep ? w_q + 1'b1 : w_q;
	assign qcnt_next = (qual && qcnt_q < cot_pkg::MAX_RES) ? qcnt_q + 5'd1 : qcnt_q;

	// entry RAM write port
	always_comb begin
		e_we    = 1'b0;
		e_waddr = n_q[TW-1:0];
		e_wdata = '{life: 16'd0, rc: rm_start_q, id: 16'(fbc_q), area: in_a,
			y: in_y, x: in_x};
		case (state_q)
			S_IDLE: begin
				e_we = acc && blob_ok && empty_q && (n_q < TD);
			end
			S_B_CHK: begin
				if (b_near) begin
					e_we    = move_q;
					e_waddr = i_q[TW-1:0];
					e_wdata = e_rdata;
					e_wdata.x = bx_q;
					e_wdata.y = by_q;
				end else begin
					e_we    = (i_q + 1'b1 == n_q) && (n_q < TD);
					e_wdata = '{life: 16'd0, rc: rm_start_q, id: next_id_q + 16'd1,
						area: ba_q, y: by_q, x: bx_q};
				end
			end
			S_F_UPD: begin
				e_we    = keep;
				e_waddr = w_q[TW-1:0];
				e_wdata = upd;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			n_q       <= '0;
			i_q       <= '0;
			w_q       <= '0;
			fbc_q     <= '0;
			j_q       <= '0;
			next_id_q <= '0;
			empty_q   <= 1'b1;
			seen_q    <= 1'b0;
			qcnt_q    <= '0;
			emit_q    <= '0;
			ovalid_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						bx_q <= in_x;
						by_q <= in_y;
						ba_q <= in_a;
						case (in_cmd)
							cot_pkg::CMD_BLOB: begin
								if (blob_ok) begin
									fbc_q <= fbc_q + 1'b1;
									if (empty_q) begin
										if (n_q < TD) begin
											n_q <= n_q + 1'b1;
										end
									end else if (n_q != '0) begin
										i_q     <= '0;
										state_q <= S_B_RD;
									end else begin
										// nothing to match against: add directly
										next_id_q <= next_id_q + 16'd1;
										n_q       <= n_q + 1'b1;
									end
								end
							end
							cot_pkg::CMD_FRAME: begin
								i_q    <= '0;
								w_q    <= '0;
								qcnt_q <= '0;
								emit_q <= '0;
								if (n_q == '0) begin
									fbc_q    <= '0;
									empty_q  <= 1'b1;
									ovalid_q <= 1'b1;
									onone_q  <= 1'b1;
									olast_q  <= 1'b1;
									oid_q    <= '0;
									ox_q     <= '0;
									oy_q     <= '0;
									oa_q     <= '0;
									otot_q   <= '0;
									state_q  <= S_E_OUT;
								end else begin
									state_q <= S_F_RD;
								end
							end
							cot_pkg::CMD_CLEAR: begin
								n_q       <= '0;
								w_q       <= '0;
								fbc_q     <= '0;
								next_id_q <= '0;
								empty_q   <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				S_B_RD: begin
					state_q <= S_B_CHK;
				end
				S_B_CHK: begin
					if (b_near) begin
						state_q <= S_IDLE;
					end else if (i_q + 1'b1 == n_q) begin
						// no match: add as a new entry if there is room
						if (n_q < TD) begin
							next_id_q <= next_id_q + 16'd1;
							n_q       <= n_q + 1'b1;
						end
						state_q <= S_IDLE;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_B_RD;
					end
				end
				S_F_RD: begin
					state_q <= S_F_ENT;
				end
				S_F_ENT: begin
					e_q    <= e_rdata;
					seen_q <= 1'b0;
					j_q    <= '0;
					state_q <= (fbc_q == '0) ? S_F_UPD : S_F_BRD;
				end
				S_F_BRD: begin
					state_q <= S_F_BCHK;
				end
				S_F_BCHK: begin
					if (f_near) begin
						seen_q  <= 1'b1;
						state_q <= S_F_UPD;
					end else if (j_q + 1'b1 == fbc_q) begin
						state_q <= S_F_UPD;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_F_BRD;
					end
				end
				S_F_UPD: begin
					w_q    <= w_next;
					qcnt_q <= qcnt_next;
					if (i_q + 1'b1 == n_q) begin
						// table compacted: start the report pass
						n_q     <= w_next;
						empty_q <= (w_next == '0);
						fbc_q   <= '0;
						i_q     <= '0;
						if (qcnt_next == 5'd0) begin
							ovalid_q <= 1'b1;
							onone_q  <= 1'b1;
							olast_q  <= 1'b1;
							oid_q    <= '0;
							ox_q     <= '0;
							oy_q     <= '0;
							oa_q     <= '0;
							otot_q   <= '0;
							state_q  <= S_E_OUT;
						end else begin
							state_q <= S_E_RD;
						end
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_F_RD;
					end
				end
				S_E_RD: begin
					state_q <= S_E_GOT;
				end
				S_E_GOT: begin
					if (e_rdata.life >= {7'd0, min_life_q}) begin
						ovalid_q <= 1'b1;
						onone_q  <= 1'b0;
						olast_q  <= (emit_q + 5'd1 == qcnt_q);
						oid_q    <= e_rdata.id;
						ox_q     <= e_rdata.x;
						oy_q     <= e_rdata.y;
						oa_q     <= e_rdata.area;
						otot_q   <= qcnt_q;
						state_q  <= S_E_OUT;
					end else if (i_q + 1'b1 == n_q) begin
						state_q <= S_IDLE;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_E_RD;
					end
				end
				S_E_OUT: begin
					if (m_tready) begin
						ovalid_q <= 1'b0;
						if (olast_q) begin
							state_q <= S_IDLE;
						end else begin
							emit_q  <= emit_q + 5'd1;
							i_q     <= i_q + 1'b1;
							state_q <= S_E_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {6'd0, otot_q, oa_q, oy_q, ox_q, oid_q};
	assign m_tlast  = olast_q;
	assign m_tuser  = onone_q;

	// a result is only presented while the report pass waits on it
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (state_q == S_E_OUT))
		else $error("result valid outside report wait");

	assert property (@(posedge clk) disable iff (!arst_n)
		(n_q <= TD) && (fbc_q <= FB))
		else $error("table or frame list count overflow");

	// the report count never exceeds the number of results a frame may give
	assert property (@(posedge clk) disable iff (!arst_n)
		(qcnt_q <= cot_pkg::MAX_RES) && (w_q <= n_q))
		else $error("report count or write pointer out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("pending result changed");

endmodule

### dv/cot_checker.sv
module cot_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic        m_tlast,
	input  logic        m_tuser,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [18:0] cfg_data,
	output int          errors,
	output int          pending
);

	localparam int DEPTH = 16;
	localparam int BLOBS = 16;

	typedef struct packed {
		logic [15:0] id;
		logic [8:0]  x;
		logic [8:0]  y;
		logic [18:0] area;
		logic [4:0]  total;
		logic        last;
		logic        none;
	} report_t;

	report_t reports_due[$];

	logic [8:0]  margin;
	logic        move_en;
	logic [18:0] area_lo, area_hi;
	logic [5:0]  rc_start;
	logic [8:0]  life_min;

	logic [8:0]  trk_x[DEPTH], trk_y[DEPTH];
	logic [18:0] trk_area[DEPTH];
	logic [15:0] trk_id[DEPTH];
	logic [5:0]  trk_rc[DEPTH];
	logic [15:0] trk_life[DEPTH];
	int          trk_count;
	logic [8:0]  seen_x[BLOBS], seen_y[BLOBS];
	int          seen_count;
	logic [15:0] id_counter;
	logic        fresh_frame;

	assign pending = reports_due.size();

	function automatic bit close_to(logic [8:0] ax, logic [8:0] ay, logic [8:0] bx,
		logic [8:0] by);
		int dx, dy, m;
		dx = int'(ax) - int'(bx);
		dy = int'(ay) - int'(by);
		m = int'(margin);
		return dx >= -m && dx <= m && dy >= -m && dy <= m;
	endfunction

	task automatic add_track(logic [8:0] x, logic [8:0] y, logic [18:0] a, logic [15:0] id);
		trk_x[trk_count] = x;
		trk_y[trk_count] = y;
		trk_area[trk_count] = a;
		trk_id[trk_count] = id;
		trk_rc[trk_count] = rc_start;
		trk_life[trk_count] = 0;
		trk_count++;
	endtask

	task automatic take_blob(logic [8:0] x, logic [8:0] y, logic [18:0] a);
		bit hit;
		int pos;
		hit = 0;
		if (a < area_lo || a > area_hi || seen_count >= BLOBS)
			return;
		pos = seen_count;
		seen_x[pos] = x;
		seen_y[pos] = y;
		seen_count++;
		if (fresh_frame) begin
			if (trk_count < DEPTH)
				add_track(x, y, a, 16'(pos));
			return;
		end
		for (int j = 0; j < trk_count && !hit; j++) begin
			if (close_to(x, y, trk_x[j], trk_y[j])) begin
				hit = 1;
				if (move_en) begin
					trk_x[j] = x;
					trk_y[j] = y;
				end
			end
		end
		if (!hit && trk_count < DEPTH) begin
			id_counter = id_counter + 16'd1;
			add_track(x, y, a, id_counter);
		end
	endtask

	// age the table, compact it in order, then queue the frame's reports
	task automatic close_frame();
		bit hit;
		int kept, cnt, first;
		report_t r;
		for (int i = 0; i < trk_count; i++) begin
			hit = 0;
			for (int j = 0; j < seen_count; j++)
				if (close_to(trk_x[i], trk_y[i], seen_x[j], seen_y[j]))
					hit = 1;
			if (hit) begin
				if (trk_life[i] != cot_pkg::LIFE_MAX)
					trk_life[i]++;
			end else if (trk_rc[i] != 0) begin
				trk_rc[i]--;
			end
		end
		kept = 0;
		for (int i = 0; i < trk_count; i++) begin
			if (trk_rc[i] != 0) begin
				trk_x[kept] = trk_x[i];
				trk_y[kept] = trk_y[i];
				trk_area[kept] = trk_area[i];
				trk_id[kept] = trk_id[i];
				trk_rc[kept] = trk_rc[i];
				trk_life[kept] = trk_life[i];
				kept++;
			end
		end
		trk_count = kept;
		seen_count = 0;
		fresh_frame = (kept == 0);
		cnt = 0;
		first = reports_due.size();
		for (int i = 0; i < kept && cnt < int'(cot_pkg::MAX_RES); i++) begin
			if (trk_life[i] >= 16'(life_min)) begin
				r = '0;
				r.id = trk_id[i];
				r.x = trk_x[i];
				r.y = trk_y[i];
				r.area = trk_area[i];
				reports_due = {reports_due, r};
				cnt++;
			end
		end
		if (cnt == 0) begin
			r = '0;
			r.last = 1;
			r.none = 1;
			reports_due = {reports_due, r};
		end else begin
			for (int i = first; i < first + cnt; i++)
				reports_due[i].total = 5'(cnt);
			reports_due[first + cnt - 1].last = 1;
		end
	endtask

	task automatic note_mismatch(report_t want, report_t got);
		errors++;
		if (errors <= 10)
			$display({"mismatch: expected id=%0d x=%0d y=%0d area=%0d total=%0d",
				" last=%0b none=%0b, got id=%0d x=%0d y=%0d area=%0d total=%0d",
				" last=%0b none=%0b"},
				want.id, want.x, want.y, want.area, want.total, want.last, want.none,
				got.id, got.x, got.y, got.area, got.total, got.last, got.none);
	endtask

	always @(posedge clk or negedge arst_n) begin
		report_t got;
		if (!arst_n) begin
			margin     = 9'd20;
			move_en    = 1'b1;
			area_lo    = 19'd655;
			area_hi    = 19'd16384;
			rc_start   = 6'd10;
			life_min   = 9'd30;
			trk_count  = 0;
			seen_count = 0;
			id_counter = '0;
			fresh_frame = 1'b1;
			errors     = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					cot_pkg::REG_MARGIN:   margin = cfg_data[8:0];
					cot_pkg::REG_MOVE:     move_en = cfg_data[0];
					cot_pkg::REG_MIN_AREA: area_lo = cfg_data;
					cot_pkg::REG_MAX_AREA: area_hi = cfg_data;
					cot_pkg::REG_RM_START: rc_start = cfg_data[5:0];
					cot_pkg::REG_MIN_LIFE: life_min = cfg_data[8:0];
					default: ;
				endcase
			end
			// compare the outgoing transfer before queueing anything new
			if (m_tvalid && m_tready) begin
				got.id    = m_tdata[15:0];
				got.x     = m_tdata[24:16];
				got.y     = m_tdata[33:25];
				got.area  = m_tdata[52:34];
				got.total = m_tdata[57:53];
				got.last  = m_tlast;
				got.none  = m_tuser;
				if (reports_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected report: id=%0d x=%0d y=%0d",
							got.id, got.x, got.y);
				end else begin
					if (got !== reports_due[0])
						note_mismatch(reports_due[0], got);
					void'(reports_due.pop_front());
				end
			end
			if (s_tvalid && s_tready) begin
				case (s_tdata[1:0])
					cot_pkg::CMD_BLOB:
						take_blob(s_tdata[10:2], s_tdata[19:11], s_tdata[38:20]);
					cot_pkg::CMD_FRAME: close_frame();
					cot_pkg::CMD_CLEAR: begin
						trk_count = 0;
						seen_count = 0;
						id_counter = '0;
						fresh_frame = 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

endmodule

### dv/tb.sv
module tb;

	// command code the block must ignore
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int LIMIT = 1000000;
	// worst end of frame: 16 entries each compared with 16 stored blobs, plus the report scan
	localparam int SETTLE = 1000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [63:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        cfg_we = 0;
	logic [2:0]  cfg_index = '0;
	logic [18:0] cfg_data = '0;

	int errors, pending;
	int cycles = 0;
	bit hold_request = 0;
	int anchor_x[6], anchor_y[6];
	logic [8:0] cur_margin;

	always #2 clk = ~clk;

	centroid_object_tracker dut (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
		.m_tdata, .m_tlast, .m_tuser, .cfg_we, .cfg_index, .cfg_data
	);

	cot_checker scoreboard (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
		.m_tdata, .m_tlast, .m_tuser, .cfg_we, .cfg_index, .cfg_data,
		.errors, .pending
	);

	// mostly no gap, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver: random stalls, plus one long hold-off when requested
	always @(negedge clk) begin
		static int stall_left = 0;
		static int hold_left = 0;
		static bit hold_done = 0;
		if (hold_request && !hold_done) begin
			hold_done = 1;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			stall_left = pick_gap();
			m_tready <= (stall_left == 0);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// present one transfer, hold it until taken, then maybe idle the bus
	task automatic send_item(logic [1:0] cmd, int x, int y, int area);
		int gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, 19'(area), 9'(y), 9'(x), cmd};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic write_reg(logic [2:0] idx, int value);
		@(negedge clk);
		s_tvalid <= 1'b0;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 19'(value);
		if (idx == cot_pkg::REG_MARGIN)
			cur_margin = 9'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// drain all reports and let any blob work finish
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic int clamp9(int v);
		return v < 0 ? 0 : (v > 511 ? 511 : v);
	endfunction

	// frames of blobs jittered around a few moving targets, with noise
	task automatic run_frames(int budget, int area_lo, int area_hi);
		int r, nblobs, k, jit;
		for (int a = 0; a < 6; a++) begin
			anchor_x[a] = $urandom_range(0, 511);
			anchor_y[a] = $urandom_range(0, 511);
		end
		while (budget > 0) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				send_item(cot_pkg::CMD_CLEAR, $urandom_range(0, 511),
					$urandom_range(0, 511), $urandom_range(0, 524287));
				budget--;
			end else if (r < 7) begin
				send_item(CMD_UNUSED, $urandom_range(0, 511), $urandom_range(0, 511),
					$urandom_range(0, 524287));
			end else begin
				// now and then overflow the frame list and the table
				nblobs = ($urandom_range(0, 19) == 0) ? $urandom_range(16, 19)
					: $urandom_range(0, 5);
				for (int b = 0; b < nblobs; b++) begin
					k = $urandom_range(0, 5);
					jit = int'(cur_margin) + 2;
					if ($urandom_range(0, 9) == 0) begin
						send_item(cot_pkg::CMD_BLOB, $urandom_range(0, 511),
							$urandom_range(0, 511), $urandom_range(0, 524287));
					end else begin
						send_item(cot_pkg::CMD_BLOB,
							clamp9(anchor_x[k] + $urandom_range(0, 2 * jit) - jit),
							clamp9(anchor_y[k] + $urandom_range(0, 2 * jit) - jit),
							$urandom_range(area_lo, area_hi));
					end
					budget--;
				end
				send_item(cot_pkg::CMD_FRAME, $urandom_range(0, 511),
					$urandom_range(0, 511), $urandom_range(0, 524287));
				budget--;
				// drift the targets
				for (int a = 0; a < 6; a++) begin
					anchor_x[a] = clamp9(anchor_x[a] + $urandom_range(0, 8) - 4);
					anchor_y[a] = clamp9(anchor_y[a] + $urandom_range(0, 8) - 4);
				end
			end
		end
	endtask

	initial begin
		cur_margin = 9'd20;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: wide window, areas up to 262144 accepted, report from first sighting
		write_reg(cot_pkg::REG_MARGIN, 20);
		write_reg(cot_pkg::REG_MOVE, 1);
		write_reg(cot_pkg::REG_MIN_AREA, 0);
		write_reg(cot_pkg::REG_MAX_AREA, 262144);
		write_reg(cot_pkg::REG_RM_START, 5);
		write_reg(cot_pkg::REG_MIN_LIFE, 0);
		send_item(cot_pkg::CMD_FRAME, 0, 0, 0);          // empty table, nothing to report
		send_item(cot_pkg::CMD_BLOB, 0, 0, 0);           // first frame: IDs by position
		send_item(cot_pkg::CMD_BLOB, 511, 511, 262144);
		send_item(cot_pkg::CMD_BLOB, 100, 100, 1000);
		send_item(cot_pkg::CMD_FRAME, 511, 511, 524287);
		send_item(cot_pkg::CMD_BLOB, 120, 80, 500);      // match on the window corner, move
		send_item(cot_pkg::CMD_BLOB, 300, 300, 777);     // new entry from the counter
		send_item(CMD_UNUSED, 511, 511, 524287);
		send_item(cot_pkg::CMD_FRAME, 0, 0, 0);
		send_item(cot_pkg::CMD_FRAME, 0, 0, 0);          // nothing seen, removal counts drop
		send_item(cot_pkg::CMD_BLOB, 0, 0, 524287);      // area above the limit, dropped
		send_item(cot_pkg::CMD_CLEAR, 0, 0, 0);
		send_item(cot_pkg::CMD_BLOB, 7, 9, 3);
		send_item(cot_pkg::CMD_FRAME, 0, 0, 0);
		wait_idle();

		// narrow area band, no move, zero window, high life threshold
		write_reg(cot_pkg::REG_MARGIN, 0);
		write_reg(cot_pkg::REG_MOVE, 0);
		write_reg(cot_pkg::REG_MIN_AREA, 500);
		write_reg(cot_pkg::REG_MAX_AREA, 1000);
		write_reg(cot_pkg::REG_RM_START, 50);
		write_reg(cot_pkg::REG_MIN_LIFE, 500);
		send_item(cot_pkg::CMD_BLOB, 10, 10, 499);
		send_item(cot_pkg::CMD_BLOB, 10, 10, 1001);
		send_item(cot_pkg::CMD_BLOB, 10, 10, 500);
		send_item(cot_pkg::CMD_BLOB, 11, 10, 1000);
		send_item(cot_pkg::CMD_FRAME, 0, 0, 0);
		wait_idle();

		// random phase: small window, short life; receiver holds off at the start
		write_reg(cot_pkg::REG_MARGIN, 6);
		write_reg(cot_pkg::REG_MOVE, 1);
		write_reg(cot_pkg::REG_MIN_AREA, 100);
		write_reg(cot_pkg::REG_MAX_AREA, 200000);
		write_reg(cot_pkg::REG_RM_START, 5);
		write_reg(cot_pkg::REG_MIN_LIFE, 1);
		hold_request = 1;
		run_frames(30, 50, 262144);
		wait_idle();

		// random phase: widest window, no move
		write_reg(cot_pkg::REG_MARGIN, 511);
		write_reg(cot_pkg::REG_MOVE, 0);
		write_reg(cot_pkg::REG_MIN_AREA, 0);
		write_reg(cot_pkg::REG_MAX_AREA, 262144);
		write_reg(cot_pkg::REG_RM_START, 8);
		write_reg(cot_pkg::REG_MIN_LIFE, 2);
		run_frames(25, 0, 262144);
		wait_idle();

		// random phase: medium window, all fresh entries reported
		write_reg(cot_pkg::REG_MARGIN, 15);
		write_reg(cot_pkg::REG_MOVE, 1);
		write_reg(cot_pkg::REG_MIN_AREA, 1000);
		write_reg(cot_pkg::REG_MAX_AREA, 5000);
		write_reg(cot_pkg::REG_RM_START, 50);
		write_reg(cot_pkg::REG_MIN_LIFE, 0);
		run_frames(30, 800, 6000);
		wait_idle();

		if (errors == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
